// File: sv/tsc_pkg.sv
`default_nettype none

package tsc_pkg;

  localparam int ROUNDS       = 3;
  localparam int SBOX_ENTRIES = 256;
  localparam int BYTE_W       = 8;
  localparam int BLK_W        = 16;
  localparam int PERM_W       = 24;
  localparam int CFG_W        = 24;
  localparam int CFG_IDX_W    = 2;
  localparam int RND_W        = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
  localparam int SBOX_AW      = $clog2(SBOX_ENTRIES);
  localparam int STEP_W       = 3;

  localparam logic [BYTE_W-1:0]    KEY_CONST_A = 8'h80;
  localparam logic [BYTE_W-1:0]    KEY_CONST_B = 8'h30;
  localparam logic [PERM_W-1:0]    PERM_RESET  = 24'hFAC688;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CTR_HI  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PERM    = 2'd2;

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t ST_IDLE = 3'd0;
  localparam step_t ST_KX0  = 3'd1;
  localparam step_t ST_KX1  = 3'd2;
  localparam step_t ST_KX2  = 3'd3;
  localparam step_t ST_RA   = 3'd4;
  localparam step_t ST_RB   = 3'd5;
  localparam step_t ST_RC   = 3'd6;
  localparam step_t ST_DONE = 3'd7;

  typedef enum logic [2:0] {
    ADDR_TBL,
    ADDR_SW1,
    ADDR_SW3,
    ADDR_HI,
    ADDR_LO
  } addr_sel_e;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_IN,
    JMP_LOOP,
    JMP_OUT
  } jump_e;

  typedef struct packed {
    logic      in_ready;
    addr_sel_e addr_sel;
    logic      ld_k1;
    logic      ld_k2;
    logic      ld_x;
    logic      ld_hi;
    logic      ld_blk;
    logic      push;
    jump_e     jump;
    step_t     target;
  } ucode_t;

  typedef struct packed {
    logic in_fire_data;
    logic last_round;
    logic out_free;
  } dp_status_t;

  // Control store: one word per step.
  function automatic ucode_t ucode_rom(input step_t s);
    ucode_t u;
    u = '0;
    u.addr_sel = ADDR_TBL;
    u.jump     = JMP_NEXT;
    u.target   = ST_IDLE;
    case (s)
      ST_IDLE: begin
        u.in_ready = 1'b1;
        u.jump     = JMP_IN;
      end
      ST_KX0: begin
        u.addr_sel = ADDR_SW1;
      end
      ST_KX1: begin
        u.ld_k1    = 1'b1;
        u.addr_sel = ADDR_SW3;
      end
      ST_KX2: begin
        u.ld_k2 = 1'b1;
      end
      ST_RA: begin
        u.ld_x     = 1'b1;
        u.addr_sel = ADDR_HI;
      end
      ST_RB: begin
        u.ld_hi    = 1'b1;
        u.addr_sel = ADDR_LO;
      end
      ST_RC: begin
        u.ld_blk = 1'b1;
        u.jump   = JMP_LOOP;
        u.target = ST_RA;
      end
      ST_DONE: begin
        u.push   = 1'b1;
        u.jump   = JMP_OUT;
        u.target = ST_IDLE;
      end
      default: begin
        u.jump = JMP_OUT;
      end
    endcase
    return u;
  endfunction

  function automatic logic [BYTE_W-1:0] nib_swap(input logic [BYTE_W-1:0] b);
    return {b[3:0], b[7:4]};
  endfunction

  // Output bit (7-i) takes input bit (7-e[i]).
  function automatic logic [BYTE_W-1:0] perm_byte(input logic [BYTE_W-1:0] b,
                                                  input logic [PERM_W-1:0] p);
    logic [BYTE_W-1:0] r;
    logic [2:0]        e;
    r = '0;
    for (int i = 0; i < BYTE_W; i++) begin
      e = p[3*i +: 3];
      r[BYTE_W-1-i] = b[3'(BYTE_W-1) - e];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: sv/tsc_ifs.sv
`default_nettype none

interface tsc_in_if;
  import tsc_pkg::*;
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [BYTE_W-1:0] table_index;
  logic [BYTE_W-1:0] table_value;
  logic [BLK_W-1:0]  data_block;

  modport source (output valid, req_type, table_index, table_value, data_block,
                  input ready);
  modport sink (input valid, req_type, table_index, table_value, data_block,
                output ready);
endinterface

interface tsc_out_if;
  import tsc_pkg::*;
  logic             valid;
  logic             ready;
  logic [BLK_W-1:0] out_block;
  logic [BLK_W-1:0] keystream_word;
  logic [BLK_W-1:0] counter_value;

  modport source (output valid, out_block, keystream_word, counter_value,
                  input ready);
  modport sink (input valid, out_block, keystream_word, counter_value,
                output ready);
endinterface

`default_nettype wire

// File: sv/toy_spn16_ctr_keystream.sv
// A data item is accepted in IDLE, then steps through KX0-KX2, ROUNDS passes of RA/RB/RC
// and DONE, where it waits until the output register is free; no new item is taken before
// that. The single-port S-box RAM sets the steps: every key-expansion and round lookup
// is one registered read, stepped by the control store. A load item writes the S-box from IDLE.
// Reset clears the step counter, block counter, output valid and the config registers
// (permutation to identity); S-box contents are undefined until written.
`default_nettype none

module toy_spn16_ctr_keystream (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [tsc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [tsc_pkg::CFG_W-1:0]     cfg_data_i,
  tsc_in_if.sink                             in_i,
  tsc_out_if.source                          out_o
);
  import tsc_pkg::*;

  ucode_t     ctrl;
  dp_status_t status;

  assign in_i.ready = ctrl.in_ready;

  tsc_sequencer u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .status_i(status),
    .ctrl_o  (ctrl)
  );

  tsc_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .status_o        (status),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_i.valid),
    .in_req_type_i   (in_i.req_type),
    .in_table_index_i(in_i.table_index),
    .in_table_value_i(in_i.table_value),
    .in_data_block_i (in_i.data_block),
    .out_valid_o     (out_o.valid),
    .out_ready_i     (out_o.ready),
    .out_block_o     (out_o.out_block),
    .out_keystream_o (out_o.keystream_word),
    .out_counter_o   (out_o.counter_value)
  );

endmodule

`default_nettype wire

// File: sv/tsc_ram.sv
`default_nettype none

module tsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

// File: sv/tsc_sequencer.sv
`default_nettype none

module tsc_sequencer (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire tsc_pkg::dp_status_t status_i,
  output tsc_pkg::ucode_t          ctrl_o
);
  import tsc_pkg::*;

  step_t step_q, step_d;

  assign ctrl_o = ucode_rom(step_q);

  always_comb begin
    step_d = step_q;
    case (ctrl_o.jump)
      JMP_NEXT: step_d = step_t'(step_q + 1'b1);
      JMP_IN: begin
        if (status_i.in_fire_data) begin
          step_d = step_t'(step_q + 1'b1);
        end
      end
      JMP_LOOP: begin
        step_d = status_i.last_round ? step_t'(step_q + 1'b1) : ctrl_o.target;
      end
      JMP_OUT: begin
        // hold until the output register can take the item
        if (status_i.out_free) begin
          step_d = ctrl_o.target;
        end
      end
      default: step_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

`default_nettype wire

// File: sv/tsc_datapath.sv
`default_nettype none

module tsc_datapath (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire tsc_pkg::ucode_t                 ctrl_i,
  output tsc_pkg::dp_status_t                  status_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [tsc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [tsc_pkg::CFG_W-1:0]       cfg_data_i,
  input  wire logic                            in_valid_i,
  input  wire logic                            in_req_type_i,
  input  wire logic [tsc_pkg::BYTE_W-1:0]      in_table_index_i,
  input  wire logic [tsc_pkg::BYTE_W-1:0]      in_table_value_i,
  input  wire logic [tsc_pkg::BLK_W-1:0]       in_data_block_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic      [tsc_pkg::BLK_W-1:0]       out_block_o,
  output logic      [tsc_pkg::BLK_W-1:0]       out_keystream_o,
  output logic      [tsc_pkg::BLK_W-1:0]       out_counter_o
);
  import tsc_pkg::*;

  logic [BLK_W-1:0]   key_q;
  logic [BYTE_W-1:0]  ctr_hi_q;
  logic [PERM_W-1:0]  perm_q;
  logic [BYTE_W-1:0]  blkctr_q;
  logic [RND_W-1:0]   rnd_q;
  logic               out_valid_q;

  logic [BLK_W-1:0]   data_q, ctr_q, blk_q, k1_q, k2_q;
  logic [BYTE_W-1:0]  hi_q;
  logic [BLK_W-1:0]   out_block_q, out_ks_q, out_ctr_q;

  logic               in_fire;
  logic               ram_we;
  logic [SBOX_AW-1:0] ram_addr;
  logic [BYTE_W-1:0]  rd;
  logic [BYTE_W-1:0]  w2c, w3c, w4c, w5c, perm_rd;
  logic [BLK_W-1:0]   rkey, xk;
  logic               out_free, push;

  assign in_fire = in_valid_i && ctrl_i.in_ready;
  assign ram_we  = in_fire && !in_req_type_i;

  assign w2c     = key_q[15:8] ^ KEY_CONST_A ^ rd;
  assign w3c     = w2c ^ key_q[7:0];
  assign w4c     = k1_q[15:8] ^ KEY_CONST_B ^ rd;
  assign w5c     = w4c ^ k1_q[7:0];
  assign perm_rd = perm_byte(rd, perm_q);

  always_comb begin
    case (rnd_q)
      RND_W'(0): rkey = key_q;
      RND_W'(1): rkey = k1_q;
      default:   rkey = k2_q;
    endcase
  end

  assign xk = blk_q ^ rkey;

  always_comb begin
    case (ctrl_i.addr_sel)
      ADDR_TBL: ram_addr = in_table_index_i;
      ADDR_SW1: ram_addr = nib_swap(key_q[7:0]);
      ADDR_SW3: ram_addr = nib_swap(w3c);
      ADDR_HI:  ram_addr = xk[15:8];
      ADDR_LO:  ram_addr = blk_q[7:0];
      default:  ram_addr = in_table_index_i;
    endcase
  end

  tsc_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(SBOX_ENTRIES)
  ) u_sbox (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(in_table_value_i),
    .rdata_o(rd)
  );

  assign out_free = !out_valid_q || out_ready_i;
  assign push     = ctrl_i.push && out_free;

  assign status_o.in_fire_data = in_fire && in_req_type_i;
  assign status_o.last_round   = (rnd_q == RND_W'(ROUNDS - 1));
  assign status_o.out_free     = out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q       <= '0;
      ctr_hi_q    <= '0;
      perm_q      <= PERM_RESET;
      blkctr_q    <= '0;
      rnd_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_KEY:    key_q    <= cfg_data_i[BLK_W-1:0];
          CFG_CTR_HI: ctr_hi_q <= cfg_data_i[BYTE_W-1:0];
          CFG_PERM:   perm_q   <= cfg_data_i[PERM_W-1:0];
          default:    ;
        endcase
      end
      if (status_o.in_fire_data) begin
        rnd_q <= '0;
      end else if (ctrl_i.ld_blk) begin
        rnd_q <= RND_W'(rnd_q + 1'b1);
      end
      if (push) begin
        blkctr_q    <= BYTE_W'(blkctr_q + 1'b1);
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (status_o.in_fire_data) begin
      data_q <= in_data_block_i;
      ctr_q  <= {ctr_hi_q, blkctr_q};
      blk_q  <= {ctr_hi_q, blkctr_q};
    end else if (ctrl_i.ld_x) begin
      blk_q <= xk;
    end else if (ctrl_i.ld_blk) begin
      blk_q <= {hi_q, perm_rd};
    end
    if (ctrl_i.ld_k1) begin
      k1_q <= {w2c, w3c};
    end
    if (ctrl_i.ld_k2) begin
      k2_q <= {w4c, w5c};
    end
    if (ctrl_i.ld_hi) begin
      hi_q <= perm_rd;
    end
    if (push) begin
      out_block_q <= data_q ^ blk_q;
      out_ks_q    <= blk_q;
      out_ctr_q   <= ctr_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_block_o     = out_block_q;
  assign out_keystream_o = out_ks_q;
  assign out_counter_o   = out_ctr_q;

endmodule

`default_nettype wire

// File: test/tb_toy_spn16_ctr_keystream.sv
`timescale 1ns / 1ps

module tb_toy_spn16_ctr_keystream;
  import tsc_pkg::*;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_DATA = 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic [PERM_W-1:0] PERM_REVERSE = 24'h053977;
  localparam logic [PERM_W-1:0] PERM_ALL_ZERO = 24'h000000;
  localparam logic [PERM_W-1:0] PERM_ALL_ONE = 24'hFFFFFF;

  localparam int PHASES = 9;
  localparam int ITEMS_PER_PHASE = 90;
  localparam int SETTLE = 20;
  localparam int HOLD_LEN = 300;
  localparam int QUIET_LIMIT = 3000;
  localparam int SHOW_MAX = 10;
  localparam int DIR_N = 17;

  typedef struct packed {
    logic [BLK_W-1:0] blk;
    logic [BLK_W-1:0] ks;
    logic [BLK_W-1:0] ctr;
  } block_res_t;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] idx;
    logic [BYTE_W-1:0] val;
    logic [BLK_W-1:0]  data;
    logic              fixed;
    block_res_t        want;
  } req_row_t;

  // The first two blocks run on an identity table, identity permutation and a zero key,
  // so the keystream is the counter XORed with the last two subkeys.
  localparam req_row_t DIR_ROWS [DIR_N] = '{
    '{REQ_DATA, 8'h00, 8'h00, 16'h0000, 1'b1, '{16'h38B8, 16'h38B8, 16'h0000}},
    '{REQ_DATA, 8'hFF, 8'hFF, 16'hFFFF, 1'b1, '{16'hC746, 16'h38B9, 16'h0001}},
    '{REQ_LOAD, 8'h00, 8'hFF, 16'h0000, 1'b0, '0},
    '{REQ_LOAD, 8'hFF, 8'h00, 16'hFFFF, 1'b0, '0},
    '{REQ_DATA, 8'h00, 8'h00, 16'h8000, 1'b0, '0},
    '{REQ_DATA, 8'hFF, 8'hFF, 16'h0001, 1'b0, '0},
    '{REQ_LOAD, 8'h08, 8'h5A, 16'h0000, 1'b0, '0},
    '{REQ_DATA, 8'h00, 8'h00, 16'h7FFF, 1'b0, '0},
    '{REQ_DATA, 8'h00, 8'h00, 16'hFFFE, 1'b0, '0},
    '{REQ_LOAD, 8'h80, 8'hA5, 16'h0000, 1'b0, '0},
    '{REQ_DATA, 8'h00, 8'h00, 16'h5555, 1'b0, '0},
    '{REQ_DATA, 8'h00, 8'h00, 16'hAAAA, 1'b0, '0},
    '{REQ_LOAD, 8'h7F, 8'h80, 16'h0000, 1'b0, '0},
    '{REQ_DATA, 8'h00, 8'h00, 16'h0000, 1'b0, '0},
    '{REQ_LOAD, 8'h01, 8'h01, 16'h0000, 1'b0, '0},
    '{REQ_DATA, 8'h00, 8'h00, 16'hFFFF, 1'b0, '0},
    '{REQ_DATA, 8'h00, 8'h00, 16'h1234, 1'b0, '0}
  };

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  tsc_in_if  in_if ();
  tsc_out_if out_if ();

  toy_spn16_ctr_keystream dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // Shadow state of the cipher
  logic [BYTE_W-1:0] tbl_m [SBOX_ENTRIES];
  logic [BLK_W-1:0]  key_m;
  logic [BYTE_W-1:0] nonce_m;
  logic [PERM_W-1:0] perm_m;
  logic [BYTE_W-1:0] ctr_lo_m;
  block_res_t        res_q [$];

  int snd_idle = 38;
  int rcv_idle = 83;
  logic hold_req;
  int quiet = 0;
  int bad_cnt = 0;
  int n_checked = 0;
  int n_blocks = 0;
  int n_loads = 0;
  int n_settings = 0;
  int n_holds = 0;

  function automatic logic [BYTE_W-1:0] shuffle_bits(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] r;
    int src;
    for (int i = 0; i < BYTE_W; i++) begin
      src = 7 - int'(perm_m[3*i +: 3]);
      r[7-i] = b[src];
    end
    return r;
  endfunction

  function automatic logic [BLK_W-1:0] cipher_word(input logic [BLK_W-1:0] ctr);
    logic [BYTE_W-1:0] w0, w1, w2, w3, w4, w5;
    logic [BLK_W-1:0]  rk [3];
    logic [BLK_W-1:0]  x;
    w0 = key_m[15:8];
    w1 = key_m[7:0];
    w2 = w0 ^ KEY_CONST_A ^ tbl_m[{w1[3:0], w1[7:4]}];
    w3 = w2 ^ w1;
    w4 = w2 ^ KEY_CONST_B ^ tbl_m[{w3[3:0], w3[7:4]}];
    w5 = w4 ^ w3;
    rk[0] = {w0, w1};
    rk[1] = {w2, w3};
    rk[2] = {w4, w5};
    x = ctr;
    for (int r = 0; r < ROUNDS; r++) begin
      x = x ^ rk[r];
      x = {shuffle_bits(tbl_m[x[15:8]]), shuffle_bits(tbl_m[x[7:0]])};
    end
    return x;
  endfunction

  // Offer one item, wait for it to be taken, then update the shadow state.
  task automatic offer(input req_row_t it);
    block_res_t r;
    while ($urandom_range(99) < snd_idle) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.req_type    <= it.kind;
    in_if.table_index <= it.idx;
    in_if.table_value <= it.val;
    in_if.data_block  <= it.data;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    if (it.kind == REQ_LOAD) begin
      tbl_m[it.idx] = it.val;
      n_loads++;
    end else begin
      r.ctr = {nonce_m, ctr_lo_m};
      r.ks  = cipher_word(r.ctr);
      r.blk = it.data ^ r.ks;
      res_q.push_back(it.fixed ? it.want : r);
      ctr_lo_m = ctr_lo_m + 1'b1;
      n_blocks++;
    end
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (res_q.size() != 0) @(posedge clk_i);
    // a trailing table write may still be in flight
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic fill_table(input bit ident);
    req_row_t it;
    for (int i = 0; i < SBOX_ENTRIES; i++) begin
      it      = '0;
      it.kind = REQ_LOAD;
      it.idx  = BYTE_W'(i);
      it.val  = ident ? BYTE_W'(i) : BYTE_W'($urandom);
      it.data = BLK_W'($urandom);
      offer(it);
    end
  endtask

  // Unused upper data bits carry junk; the block must mask them.
  task automatic program_regs(input logic [BLK_W-1:0] key, input logic [BYTE_W-1:0] nonce,
                              input logic [PERM_W-1:0] perm, input bit poke_spare);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_KEY;
    cfg_data_i <= {BYTE_W'($urandom), key};
    @(posedge clk_i);
    key_m = key;
    cfg_idx_i  <= CFG_CTR_HI;
    cfg_data_i <= {BLK_W'($urandom), nonce};
    @(posedge clk_i);
    nonce_m = nonce;
    cfg_idx_i  <= CFG_PERM;
    cfg_data_i <= perm;
    @(posedge clk_i);
    perm_m = perm;
    if (poke_spare) begin
      cfg_idx_i  <= CFG_SPARE;
      cfg_data_i <= CFG_W'($urandom);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  initial begin : clock
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin : rx_ready
    hold_req     = 1'b0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        // hold off the output long enough to back up the input side
        hold_req     <= 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk_i);
        n_holds++;
      end else begin
        out_if.ready <= rst_ni && ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    block_res_t got;
    block_res_t want;
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                 quiet, res_q.size());
        $display("tb_toy_spn16_ctr_keystream: errors");
        $finish;
      end
      if (out_if.valid && out_if.ready) begin
        got = '{out_if.out_block, out_if.keystream_word, out_if.counter_value};
        n_checked++;
        if (res_q.size() == 0) begin
          bad_cnt++;
          if (bad_cnt <= SHOW_MAX)
            $display("%0t: unexpected result out=%h ks=%h ctr=%h",
                     $realtime, got.blk, got.ks, got.ctr);
        end else begin
          want = res_q.pop_front();
          if (got.blk !== want.blk || got.ks !== want.ks || got.ctr !== want.ctr) begin
            bad_cnt++;
            if (bad_cnt <= SHOW_MAX)
              $display("%0t: mismatch out=%h/%h ks=%h/%h ctr=%h/%h (expected/actual)",
                       $realtime, want.blk, got.blk, want.ks, got.ks, want.ctr, got.ctr);
          end
        end
      end
    end
  end

  initial begin : stimulus
    req_row_t it;
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = CFG_KEY;
    cfg_data_i        = '0;
    in_if.valid       = 1'b0;
    in_if.req_type    = REQ_LOAD;
    in_if.table_index = '0;
    in_if.table_value = '0;
    in_if.data_block  = '0;
    foreach (tbl_m[i]) tbl_m[i] = '0;
    key_m    = '0;
    nonce_m  = '0;
    perm_m   = PERM_RESET;
    ctr_lo_m = '0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // identity table first, so the opening blocks are easy to reason about
    fill_table(1'b1);
    for (int k = 0; k < DIR_N; k++) offer(DIR_ROWS[k]);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      case (ph)
        0: program_regs(16'h0000, 8'h00, PERM_RESET, 1'b1);
        1: program_regs(16'hFFFF, 8'hFF, PERM_ALL_ZERO, 1'b0);
        2: program_regs(BLK_W'($urandom), BYTE_W'($urandom), PERM_ALL_ONE, 1'b0);
        3: program_regs(BLK_W'($urandom), BYTE_W'($urandom), PERM_REVERSE, 1'b1);
        default: begin
          program_regs(BLK_W'($urandom), BYTE_W'($urandom), PERM_W'($urandom),
                       $urandom_range(1));
        end
      endcase
      if (ph % 3 == 0) fill_table(1'b0);
      case (ph / 3)
        0: begin
          snd_idle = 38;
          rcv_idle = 83;
        end
        1: begin
          snd_idle = 83;
          rcv_idle = 38;
        end
        default: begin
          snd_idle = 0;
          rcv_idle = 0;
        end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ((ph == 1 || ph == 7) && n == 40) hold_req <= 1'b1;
        if (ph == 4 && n == 50) drain_results();
        it = '0;
        it.idx  = BYTE_W'($urandom);
        it.val  = BYTE_W'($urandom);
        it.data = BLK_W'($urandom);
        if ($urandom_range(9) == 0) begin
          it.kind = REQ_LOAD;
        end else begin
          it.kind = REQ_DATA;
          case ($urandom_range(15))
            0: it.data = 16'h0000;
            1: it.data = 16'hFFFF;
            default: ;
          endcase
        end
        offer(it);
      end
    end

    drain_results();
    $display("run covered %0d blocks and %0d table writes over %0d register settings",
             n_blocks, n_loads, n_settings);
    $display("%0d results checked, %0d output hold-offs, %0d counter wraps",
             n_checked, n_holds, n_blocks / 256);
    if (bad_cnt == 0 && res_q.size() == 0) begin
      $display("tb_toy_spn16_ctr_keystream: clean");
    end else begin
      $display("%0d mismatches, %0d results never seen", bad_cnt, res_q.size());
      $display("tb_toy_spn16_ctr_keystream: errors");
    end
    $finish;
  end

endmodule
